// File: rtl/sle_pkg.sv
// shared types and codes for the sorted list engine
package sle_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_CMP    = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } cell_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [KEY_W-1:0] entry;
    logic                    valid;
    logic                    ge;
  } cell_link_t;

endpackage

// File: rtl/sle_cell.sv
// one storage cell of the sorted list: entry, valid bit and compare flags
module sle_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  sle_pkg::cell_op_t              op,
  input  logic signed [sle_pkg::KEY_W-1:0] key,
  input  sle_pkg::cell_link_t            left,
  input  sle_pkg::cell_link_t            right,
  output sle_pkg::cell_link_t            self,
  output logic                           eq
);
  import sle_pkg::*;

  logic signed [KEY_W-1:0] entry;
  logic                    valid;
  logic                    ge;
  logic                    eq_flag;
  logic                    first_ge;

  // this cell holds the first entry at or above the key, or is the first empty cell
  assign first_ge = ge && !left.ge;

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ge      <= 1'b0;
      eq_flag <= 1'b0;
    end else begin
      case (op)
        OP_CMP: begin
          ge      <= !valid || (entry >= key);
          eq_flag <= valid && (entry == key);
        end
        OP_INSERT: begin
          if (ge) begin
            valid <= first_ge ? 1'b1 : left.valid;
          end
        end
        OP_DELETE: begin
          if (ge) begin
            valid <= right.valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stored value shifts right on insert, left on delete
  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (ge) begin
          entry <= first_ge ? key : left.entry;
        end
      end
      OP_DELETE: begin
        if (ge) begin
          entry <= right.entry;
        end
      end
      default: begin
      end
    endcase
  end

  assign self.entry = entry;
  assign self.valid = valid;
  assign self.ge    = ge;
  assign eq         = eq_flag;

endmodule

// File: rtl/sorted_list_engine_top.sv
// top level of the sorted list engine: command control and the row of cells
//
// Keeps an ascending sorted multiset of signed 32-bit values in a row of
// CAPACITY cells. Each input beat carries a command (insert, search, delete)
// and a value; each gives one output beat with a status and the entry count
// after the operation (count modulo 64). An item passes three steps from
// acceptance to its result: the command is registered, every cell compares
// its entry with the broadcast key, and the cells shift toward or away from
// the insertion point and the result is written to the output register. A new
// item is accepted while the previous result still waits to be taken; the
// update stage stalls only if that result is still pending when the next one
// is ready. Entries hold no value until written.
module sorted_list_engine_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sle_pkg::CMD_W-1:0]         command,
  input  logic signed [sle_pkg::KEY_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sle_pkg::STATUS_W-1:0]      status,
  output logic [sle_pkg::COUNT_W-1:0]       entry_count
);
  import sle_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [CMD_W-1:0]        cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [STATUS_W-1:0]     status_next;
  cell_op_t                op;
  logic                    out_free;
  logic                    any_eq;
  logic                    full;
  logic                    empty;
  logic                    finish;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  cell_link_t          links [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_UPD) && out_free;
  assign any_eq   = |eq_vec;
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_in;
    cell_link_t right_in;

    if (i == 0) begin : g_head
      assign left_in = '{entry: '0, valid: 1'b1, ge: 1'b0};
    end else begin : g_mid_l
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = '{entry: '0, valid: 1'b0, ge: 1'b1};
    end else begin : g_mid_r
      assign right_in = links[i+1];
    end

    sle_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (op),
      .key   (key_q),
      .left  (left_in),
      .right (right_in),
      .self  (links[i]),
      .eq    (eq_vec[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // state sequencing, cell operation and the decision for the update stage
  always_comb begin
    op          = OP_HOLD;
    count_next  = count;
    status_next = ST_NOT_FOUND;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        op         = OP_CMP;
        state_next = S_UPD;
      end
      S_UPD: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              status_next = ST_INSERTED;
              count_next  = count + 1'b1;
              op          = finish ? OP_INSERT : OP_HOLD;
            end
          end
          CMD_DELETE: begin
            if (empty) begin
              status_next = ST_EMPTY;
            end else if (any_eq) begin
              status_next = ST_DELETED;
              count_next  = count - 1'b1;
              op          = finish ? OP_DELETE : OP_HOLD;
            end else begin
              status_next = ST_ABSENT;
            end
          end
          default: begin
            status_next = any_eq ? ST_FOUND : ST_NOT_FOUND;
          end
        endcase
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input beat capture and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= command;
      key_q <= value;
    end
    if (finish) begin
      status    <= status_next;
      count_ext <= {{COUNT_W{1'b0}}, count_next};
    end
  end

  assign entry_count = count_ext[COUNT_W-1:0];

  // in idle, the number of valid cells equals the count
  a_valid_prefix : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(valid_vec) == int'(count)))
    else $error("cell valid bits disagree with entry count");

  // a completed insert grows the count by one
  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (finish && (cmd_q == CMD_INSERT) && !full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the count");

  // a full refusal only when every cell is in use
  a_full_status : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> full)
    else $error("full status with free cells");

  // count never exceeds the number of cells
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    finish |=> (count <= CAP_CNT))
    else $error("entry count beyond capacity");

endmodule

// File: sim/tb_top.sv
// testbench for the sorted list engine: random and directed commands against a local list model
`timescale 1ns / 100ps

module tb_top;
  import sle_pkg::*;

  localparam int unsigned CAPACITY = 32;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned IDLE_PCT = 27;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] val;
  } list_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] command = CMD_INSERT;
  logic signed [KEY_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] entry_count;

  list_cmd_t cmd_backlog[$];
  list_result_t expected_results[$];
  logic signed [KEY_W-1:0] value_pool[$];
  list_cmd_t tx_beat;

  // local copy of the sorted table
  logic signed [KEY_W-1:0] shelf [CAPACITY];
  int unsigned shelf_fill = 0;

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cyc = 0;
  logic rx_hold = 1'b0;

  sorted_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // apply one command to the local table and return the status it gives
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic signed [KEY_W-1:0] val);
    list_result_t res;
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < shelf_fill && shelf[pos] < val) pos++;
    if (cmd == CMD_INSERT) begin
      if (shelf_fill >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (i = shelf_fill; i > pos; i--) shelf[i] = shelf[i-1];
        shelf[pos] = val;
        shelf_fill++;
        res.status = ST_INSERTED;
      end
    end else if (cmd == CMD_DELETE) begin
      if (shelf_fill == 0) begin
        res.status = ST_EMPTY;
      end else if (pos < shelf_fill && shelf[pos] == val) begin
        for (i = pos; i + 1 < shelf_fill; i++) shelf[i] = shelf[i+1];
        shelf_fill--;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_ABSENT;
      end
    end else begin
      // search, and the unused code behaves as search
      if (pos < shelf_fill && shelf[pos] == val) res.status = ST_FOUND;
      else res.status = ST_NOT_FOUND;
    end
    res.count = COUNT_W'(shelf_fill);
    return res;
  endfunction

  // values biased toward duplicates and the ends of the range
  function automatic logic signed [KEY_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return int'($urandom_range(0, 8)) - 4;
    if (roll < 45) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MIN + 1;
        2: return KEY_MAX;
        3: return KEY_MAX - 1;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_item(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] val);
    list_cmd_t item;
    item.cmd = cmd;
    item.val = val;
    cmd_backlog.push_back(item);
    if (cmd == CMD_INSERT) value_pool.push_back(val);
  endtask

  // stimulus: directed corner cases, then random segments that fill, balance and drain
  initial begin : stimulus
    int unsigned n;
    int unsigned seg_len;
    int unsigned roll;
    int unsigned idx;
    mix_t mix;
    logic [CMD_W-1:0] c;
    logic signed [KEY_W-1:0] v;

    // empty table cases
    queue_item(CMD_SEARCH, 0);
    queue_item(CMD_DELETE, 0);
    queue_item(CMD_UNUSED, KEY_MAX);
    // extremes and duplicates
    queue_item(CMD_INSERT, KEY_MIN);
    queue_item(CMD_INSERT, KEY_MAX);
    queue_item(CMD_INSERT, 0);
    queue_item(CMD_INSERT, -1);
    queue_item(CMD_INSERT, 1);
    queue_item(CMD_INSERT, 0);
    queue_item(CMD_INSERT, 32'shAAAA_AAAA);
    queue_item(CMD_INSERT, 32'sh5555_5555);
    queue_item(CMD_SEARCH, 0);
    queue_item(CMD_SEARCH, 5);
    queue_item(CMD_UNUSED, KEY_MAX);
    queue_item(CMD_UNUSED, 7);
    // first occurrence removal, then absent value
    queue_item(CMD_DELETE, 0);
    queue_item(CMD_DELETE, 0);
    queue_item(CMD_DELETE, 0);
    queue_item(CMD_DELETE, KEY_MIN);
    queue_item(CMD_DELETE, KEY_MAX);
    queue_item(CMD_SEARCH, KEY_MIN);
    queue_item(CMD_SEARCH, 32'sh5555_5555);

    n = 0;
    mix = MIX_FILL;
    while (n < RANDOM_ITEMS) begin
      seg_len = $urandom_range(50, 70);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL: c = roll < 85 ? CMD_INSERT : (roll < 95 ? CMD_SEARCH : CMD_DELETE);
          MIX_DRAIN: c = roll < 80 ? CMD_DELETE : (roll < 95 ? CMD_SEARCH : CMD_INSERT);
          default: c = roll < 40 ? CMD_INSERT : (roll < 75 ? CMD_SEARCH : CMD_DELETE);
        endcase
        if (c == CMD_SEARCH && $urandom_range(0, 4) == 0) c = CMD_UNUSED;
        // searches and deletes often hit values that were inserted, mostly so while draining
        if (c != CMD_INSERT && value_pool.size() != 0 &&
            $urandom_range(0, 99) < (mix == MIX_DRAIN ? 90 : 50)) begin
          idx = $urandom_range(0, value_pool.size() - 1);
          v = value_pool[idx];
          if (c == CMD_DELETE) value_pool.delete(idx);
        end else begin
          v = pick_value();
        end
        queue_item(c, v);
        n++;
      end
      case (mix)
        MIX_FILL: mix = MIX_BALANCED;
        MIX_BALANCED: mix = MIX_DRAIN;
        default: mix = MIX_FILL;
      endcase
    end
  end

  // input driver: predicts each accepted beat and offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_list_command(command, value));
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 &&
            !((cyc < 500 || cyc >= 800) && $urandom_range(0, 99) < IDLE_PCT)) begin
          tx_beat = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          command <= tx_beat.cmd;
          value <= tx_beat.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output ready with random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold &&
                   !((cyc < 650 || cyc >= 950) && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin : rx_holdoff
    wait (results_seen >= 150);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: status %0d entry_count %0d",
                 $time, status, entry_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, status);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $display("%0t entry_count mismatch: expected %0d actual %0d",
                   $time, want.count, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // reset, then wait for the backlog and the expected results to drain
  initial begin : run_control
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[sorted_list_engine_top] OK");
    end else begin
      $display("[sorted_list_engine_top] ERROR");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #1000000;
    $display("[sorted_list_engine_top] ERROR");
    $finish;
  end

endmodule

// File: sorted_list_engine_top.f
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sorted_list_engine_top.sv
sim/tb_top.sv
